FILE: rtl/core/refcounted_entry_cache_lru_free_defines.svh
// Assertion macros for the entry cache RTL.
`ifndef REFCOUNTED_ENTRY_CACHE_LRU_FREE_DEFINES_SVH
`define REFCOUNTED_ENTRY_CACHE_LRU_FREE_DEFINES_SVH

`ifndef SYNTH
// Checked property, disabled while reset is high.
`define RCELF_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, live during reset as well.
`define RCELF_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCELF_ASSERT_RST(lbl, clk, rst, prop, msg)
`define RCELF_ASSERT(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/core/rcelf_pkg.sv
// Types and constants of the reference-counted entry cache.
`default_nettype none
package rcelf_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int FREE_W  = $clog2(ENTRIES + 1);
   localparam int CNT_W   = 16;
   localparam int DEV_W   = 16;
   localparam int NUM_W   = 32;
   localparam int SLOT_W  = 6;
   localparam int LOG_E   = $clog2(ENTRIES);
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // Result status codes.
   typedef enum logic [2:0] {
      ST_HIT    = 3'd0,
      ST_MISS   = 3'd1,
      ST_NONE   = 3'd2,
      ST_USED   = 3'd3,
      ST_FREED  = 3'd4,
      ST_UNUSED = 3'd5,
      ST_OVF    = 3'd6
   } status_type;

   // Commands to one entry cell.
   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_INC  = 2'd1,
      CMD_LOAD = 2'd2,
      CMD_DEC  = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         dirty;
   } entry_ctl_type;

   typedef struct packed {
      logic             shift;
      logic             append;
      logic [IDX_W-1:0] app_slot;
   } fifo_ctl_type;

   typedef struct packed {
      logic              op;
      logic [DEV_W-1:0]  dev;
      logic [NUM_W-1:0]  num;
      logic [SLOT_W-1:0] slot;
      logic              dirty;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot_out;
      logic              write_back;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/core/rcelf_entry_cell.sv
// One cache entry: key, valid, reference count, modified mark and free flag.
`default_nettype none
module rcelf_entry_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rcelf_pkg::entry_ctl_type    ctl,
   input  wire logic [rcelf_pkg::DEV_W-1:0] dev,
   input  wire logic [rcelf_pkg::NUM_W-1:0] num,
   output logic                             match,
   output logic [rcelf_pkg::CNT_W-1:0]      count,
   output logic                             mark,
   output logic                             on_free
);

   logic                        valid_ff, valid_in;
   logic [rcelf_pkg::DEV_W-1:0] dev_ff, dev_in;
   logic [rcelf_pkg::NUM_W-1:0] num_ff, num_in;
   logic [rcelf_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                        mark_ff, mark_in;
   logic                        free_ff, free_in;

   // Key compare against the pending request.
   assign match   = valid_ff && (dev_ff == dev) && (num_ff == num);
   assign count   = cnt_ff;
   assign mark    = mark_ff;
   assign on_free = free_ff;

   // Apply the command for this cycle.
   always_comb begin
      valid_in = valid_ff;
      dev_in   = dev_ff;
      num_in   = num_ff;
      cnt_in   = cnt_ff;
      mark_in  = mark_ff;
      free_in  = free_ff;
      case (ctl.cmd)
         rcelf_pkg::CMD_INC: begin
            cnt_in  = cnt_ff + rcelf_pkg::CNT_W'(1);
            free_in = 1'b0;
         end
         rcelf_pkg::CMD_LOAD: begin
            valid_in = 1'b1;
            dev_in   = dev;
            num_in   = num;
            cnt_in   = rcelf_pkg::CNT_W'(1);
            mark_in  = 1'b0;
            free_in  = 1'b0;
         end
         rcelf_pkg::CMD_DEC: begin
            cnt_in = cnt_ff - rcelf_pkg::CNT_W'(1);
            if (cnt_ff == rcelf_pkg::CNT_W'(1)) begin
               mark_in = 1'b0;
               free_in = 1'b1;
            end else begin
               mark_in = mark_ff | ctl.dirty;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state resets; the key is gated by valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         mark_ff  <= 1'b0;
         free_ff  <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         mark_ff  <= mark_in;
         free_ff  <= free_in;
      end
      dev_ff <= dev_in;
      num_ff <= num_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/rcelf_fifo_cell.sv
// One position of the free-list queue; it takes its upper neighbor on a removal.
`default_nettype none
module rcelf_fifo_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [rcelf_pkg::IDX_W-1:0] reset_slot,
   input  wire rcelf_pkg::fifo_ctl_type     ctl,
   input  wire logic [rcelf_pkg::IDX_W-1:0] next_slot,
   input  wire logic                        next_valid,
   input  wire logic [rcelf_pkg::IDX_W-1:0] rem_slot,
   output logic [rcelf_pkg::IDX_W-1:0]      slot,
   output logic                             valid,
   output logic                             match
);

   logic [rcelf_pkg::IDX_W-1:0] slot_ff, slot_in;
   logic                        valid_ff, valid_in;

   assign slot  = slot_ff;
   assign valid = valid_ff;
   assign match = valid_ff && (slot_ff == rem_slot);

   // Shift down on a removal at or below this position, or take an append.
   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      if (ctl.shift) begin
         slot_in  = next_slot;
         valid_in = next_valid;
      end else if (ctl.append) begin
         slot_in  = ctl.app_slot;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= reset_slot;
         valid_ff <= 1'b1;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/refcounted_entry_cache_lru_free.sv
// Top level of the reference-counted entry cache with an LRU free queue.
// Each request passes through capture, key compare in all entry cells, then decide and update.
// busy is high in the look and decide states after a transfer; no new request is taken while it is high.
// The result strobe is registered out of the decide state and is high for one cycle.
// The receiver cannot stall, so a result never waits and never holds the input off.
// Synchronous reset: all entries invalid, every entry free in index order, no pass needed.
`default_nettype none
`include "refcounted_entry_cache_lru_free_defines.svh"
module refcounted_entry_cache_lru_free (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire rcelf_pkg::req_type req_data,
   output logic                    rsp_strobe,
   output rcelf_pkg::rsp_type      rsp_data
);

   localparam int E = rcelf_pkg::ENTRIES;
   localparam int W = rcelf_pkg::IDX_W;

   typedef enum logic [1:0] {S_IDLE, S_LOOK, S_DEC} state_type;

   state_type                    state_ff;
   rcelf_pkg::req_type           req_ff;
   logic [E-1:0]                 hit_ff;
   logic [rcelf_pkg::FREE_W-1:0] free_cnt_ff, free_cnt_in;
   logic                         rsp_strobe_ff;
   rcelf_pkg::rsp_type           rsp_ff, rsp_in;

   logic [E-1:0]                 cell_match;
   logic [rcelf_pkg::CNT_W-1:0]  cell_cnt [E];
   logic [E-1:0]                 cell_mark;
   logic [E-1:0]                 cell_free;
   logic [W-1:0]                 q_slot [E+1];
   logic [E:0]                   q_valid;
   logic [E-1:0]                 q_match;
   logic [E-1:0]                 pfx [rcelf_pkg::LOG_E+1];

   logic                         act;
   logic                         hit_any;
   logic [W-1:0]                 hit_idx, sel_idx, put_idx;
   logic [rcelf_pkg::CNT_W-1:0]  sel_cnt;
   logic                         put_range;
   rcelf_pkg::cell_cmd_type      cmd;
   logic [W-1:0]                 cmd_idx;
   logic                         rem_en, app_en;
   logic [W-1:0]                 rem_slot;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign act        = (state_ff == S_DEC);

   // Encode the hit vector and pick the addressed entry.
   always_comb begin
      hit_idx = '0;
      for (int j = 0; j < E; j++) begin
         hit_idx = hit_idx | (hit_ff[j] ? W'(j) : W'(0));
      end
   end
   assign hit_any   = |hit_ff;
   assign put_idx   = req_ff.slot[W-1:0];
   assign put_range = ({1'b0, req_ff.slot} < (rcelf_pkg::SLOT_W + 1)'(E));
   assign sel_idx   = req_ff.op ? put_idx : hit_idx;
   assign sel_cnt   = cell_cnt[sel_idx];

   // Decide the result and the updates to the cells.
   always_comb begin
      cmd      = rcelf_pkg::CMD_NONE;
      cmd_idx  = sel_idx;
      rem_en   = 1'b0;
      rem_slot = hit_idx;
      app_en   = 1'b0;
      rsp_in   = '0;
      if (!req_ff.op) begin
         if (hit_any) begin
            rsp_in.slot_out = rcelf_pkg::SLOT_W'(hit_idx);
            if (sel_cnt == rcelf_pkg::COUNT_MAX) begin
               rsp_in.status = rcelf_pkg::ST_OVF;
            end else begin
               rsp_in.status = rcelf_pkg::ST_HIT;
               cmd           = rcelf_pkg::CMD_INC;
               rem_en        = cell_free[hit_idx];
            end
         end else if (free_cnt_ff == '0) begin
            rsp_in.status = rcelf_pkg::ST_NONE;
         end else begin
            rsp_in.status   = rcelf_pkg::ST_MISS;
            rsp_in.slot_out = rcelf_pkg::SLOT_W'(q_slot[0]);
            cmd             = rcelf_pkg::CMD_LOAD;
            cmd_idx         = q_slot[0];
            rem_en          = 1'b1;
            rem_slot        = q_slot[0];
         end
      end else begin
         rsp_in.slot_out = req_ff.slot;
         if (!put_range || sel_cnt == '0) begin
            rsp_in.status = rcelf_pkg::ST_UNUSED;
         end else begin
            cmd = rcelf_pkg::CMD_DEC;
            if (sel_cnt == rcelf_pkg::CNT_W'(1)) begin
               rsp_in.status     = rcelf_pkg::ST_FREED;
               rsp_in.write_back = cell_mark[put_idx] | req_ff.dirty;
               app_en            = 1'b1;
            end else begin
               rsp_in.status = rcelf_pkg::ST_USED;
            end
         end
      end
   end

   // Entry cells.
   for (genvar j = 0; j < E; j++) begin : g_entry
      rcelf_pkg::entry_ctl_type ctl;
      always_comb begin
         ctl.cmd   = (act && cmd_idx == W'(j)) ? cmd : rcelf_pkg::CMD_NONE;
         ctl.dirty = req_ff.dirty;
      end
      rcelf_entry_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .dev     (req_ff.dev),
         .num     (req_ff.num),
         .match   (cell_match[j]),
         .count   (cell_cnt[j]),
         .mark    (cell_mark[j]),
         .on_free (cell_free[j])
      );
   end

   // Prefix OR of the removal match, so the matching position and every position above it shift down.
   assign pfx[0] = q_match & {E{act && rem_en}};
   for (genvar s = 0; s < rcelf_pkg::LOG_E; s++) begin : g_pfx
      for (genvar j = 0; j < E; j++) begin : g_bit
         if (j >= (1 << s)) begin : g_or
            assign pfx[s+1][j] = pfx[s][j] | pfx[s][j - (1 << s)];
         end else begin : g_pass
            assign pfx[s+1][j] = pfx[s][j];
         end
      end
   end

   // Free-list queue, head at position zero.
   assign q_slot[E]  = '0;
   assign q_valid[E] = 1'b0;
   for (genvar j = 0; j < E; j++) begin : g_fifo
      rcelf_pkg::fifo_ctl_type fctl;
      always_comb begin
         fctl.shift    = pfx[rcelf_pkg::LOG_E][j];
         fctl.append   = act && app_en && (free_cnt_ff == rcelf_pkg::FREE_W'(j));
         fctl.app_slot = put_idx;
      end
      rcelf_fifo_cell u_fifo (
         .clock      (clock),
         .reset      (reset),
         .reset_slot (W'(j)),
         .ctl        (fctl),
         .next_slot  (q_slot[j+1]),
         .next_valid (q_valid[j+1]),
         .rem_slot   (rem_slot),
         .slot       (q_slot[j]),
         .valid      (q_valid[j]),
         .match      (q_match[j])
      );
   end

   // Free count follows removals and appends.
   always_comb begin
      free_cnt_in = free_cnt_ff;
      if (act && rem_en) begin
         free_cnt_in = free_cnt_ff - rcelf_pkg::FREE_W'(1);
      end else if (act && app_en) begin
         free_cnt_in = free_cnt_ff + rcelf_pkg::FREE_W'(1);
      end
   end

   // Sequencer and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         free_cnt_ff   <= rcelf_pkg::FREE_W'(E);
      end else begin
         rsp_strobe_ff <= 1'b0;
         free_cnt_ff   <= free_cnt_in;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               state_ff <= S_DEC;
            end
            S_DEC: begin
               state_ff      <= S_IDLE;
               rsp_strobe_ff <= 1'b1;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (state_ff == S_IDLE && start) begin
         req_ff <= req_data;
      end
      if (state_ff == S_LOOK) begin
         hit_ff <= cell_match;
      end
      if (act) begin
         rsp_ff <= rsp_in;
      end
   end

   `RCELF_ASSERT_RST(a_busy_after_start, clock, reset, (start && !busy) |=> busy, "start not taken")
   `RCELF_ASSERT_RST(a_strobe_idle, clock, reset, rsp_strobe |-> !busy, "result while busy")
   `RCELF_ASSERT_RST(a_free_count, clock, reset, free_cnt_ff == rcelf_pkg::FREE_W'($countones(q_valid)), "free count mismatch")
   `RCELF_ASSERT_RST(a_get_no_wb, clock, reset, (rsp_strobe && !$past(req_ff.op)) |-> !rsp_data.write_back, "write-back on get")

endmodule
`default_nettype wire
